// ----- hdl/rtsk_pkg.sv -----
// ----------------------------------------------------------------------------
// rtsk_pkg
// Shared codes and types of the task scheduler kernel: task states, request
// modes, status codes, register indexes, controller commands and status.
// ----------------------------------------------------------------------------
package rtsk_pkg;

  localparam int TIW = 4;    // task index width
  localparam int PRW = 3;    // priority width
  localparam int SMW = 3;    // semaphore index width
  localparam int TKW = 16;   // sleep tick width
  localparam int CNW = 8;    // semaphore count width

  // task states
  localparam logic [2:0] ST_INVALID = 3'd0;
  localparam logic [2:0] ST_UNRUN   = 3'd1;
  localparam logic [2:0] ST_READY   = 3'd2;
  localparam logic [2:0] ST_DELAYED = 3'd3;
  localparam logic [2:0] ST_BLOCKED = 3'd4;

  // request modes
  localparam logic [3:0] MD_TICK    = 4'd0;
  localparam logic [3:0] MD_YIELD   = 4'd1;
  localparam logic [3:0] MD_SLEEP   = 4'd2;
  localparam logic [3:0] MD_WAIT    = 4'd3;
  localparam logic [3:0] MD_POST    = 4'd4;
  localparam logic [3:0] MD_CREATE  = 4'd5;
  localparam logic [3:0] MD_DESTROY = 4'd6;
  localparam logic [3:0] MD_RESTART = 4'd7;
  localparam logic [3:0] MD_SETPRI  = 4'd8;

  // result status
  localparam logic [1:0] STS_OK     = 2'd0;
  localparam logic [1:0] STS_NONE   = 2'd1;
  localparam logic [1:0] STS_QFULL  = 2'd2;
  localparam logic [1:0] STS_NOSLOT = 2'd3;

  // register indexes
  localparam logic [2:0] CFG_RR      = 3'd0;
  localparam logic [2:0] CFG_PREEMPT = 3'd1;
  localparam logic [2:0] CFG_SEM0    = 3'd2;

  localparam logic [CNW-1:0] COUNT_MAX = 8'hFF;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_SLEEP,
    OP_WAIT,
    OP_POST_CNT,
    OP_QSETUP,
    OP_QREAD,
    OP_QCMP,
    OP_SREAD,
    OP_SWRITE,
    OP_QDONE,
    OP_TFIN,
    OP_TICK_STEP,
    OP_CREATE_STEP,
    OP_SETPRI,
    OP_PINIT,
    OP_PSTEP,
    OP_PFIN,
    OP_OUT
  } op_t;

  // task table address select
  typedef enum logic [2:0] {
    A_TIX,
    A_CUR,
    A_SCAN,
    A_QT,
    A_PICK
  } asel_t;

  typedef struct packed {
    op_t   op;
    asel_t asel;
  } ctl_cmd_t;

  typedef struct packed {
    logic [3:0] mode;
    logic       tix_ok;
    logic       tix_blocked;
    logic       bsem_ok;
    logic       sem_ok;
    logic       qlen_nz;
    logic       scan_last;
    logic       cand_invalid;
    logic       q_match;
    logic       q_more;
    logic       q_more2;
    logic       is_post;
    logic       preempt;
    logic       out_free;
  } dp_stat_t;

endpackage

// ----- hdl/rtsk_ram.sv -----
// ----------------------------------------------------------------------------
// rtsk_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module rtsk_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 40,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- hdl/rtsk_ctrl.sv -----
// ----------------------------------------------------------------------------
// rtsk_ctrl
// Sequencer of the kernel: steps one request through table scans, wait
// queue edits and the reschedule scan, then hands the result word out.
// ----------------------------------------------------------------------------
module rtsk_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  rtsk_pkg::dp_stat_t  stat,
  output rtsk_pkg::ctl_cmd_t  cmd
);

  import rtsk_pkg::*;

  typedef enum logic [13:0] {
    S_IDLE   = 14'b00000000000001,
    S_DISP   = 14'b00000000000010,
    S_TICK   = 14'b00000000000100,
    S_CREATE = 14'b00000000001000,
    S_QRD    = 14'b00000000010000,
    S_QCMP   = 14'b00000000100000,
    S_SRD    = 14'b00000001000000,
    S_SWR    = 14'b00000010000000,
    S_QDONE  = 14'b00000100000000,
    S_TFIN   = 14'b00001000000000,
    S_PINIT  = 14'b00010000000000,
    S_PSCAN  = 14'b00100000000000,
    S_PFIN   = 14'b01000000000000,
    S_OUT    = 14'b10000000000000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd.op    = OP_NONE;
    cmd.asel  = A_TIX;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        if (stat.mode == MD_SLEEP || stat.mode == MD_WAIT) begin
          cmd.asel = A_CUR;
        end
        unique case (stat.mode)
          MD_TICK:  state_nxt = S_TICK;
          MD_YIELD: state_nxt = S_PINIT;
          MD_SLEEP: begin
            cmd.op    = OP_SLEEP;
            state_nxt = S_PINIT;
          end
          MD_WAIT: begin
            cmd.op    = OP_WAIT;
            state_nxt = S_PINIT;
          end
          MD_POST: begin
            if (stat.sem_ok && stat.qlen_nz) begin
              cmd.op    = OP_QSETUP;
              state_nxt = S_QRD;
            end else begin
              cmd.op    = OP_POST_CNT;
              state_nxt = S_PINIT;
            end
          end
          MD_CREATE: state_nxt = S_CREATE;
          MD_DESTROY, MD_RESTART: begin
            if (!stat.tix_ok) begin
              state_nxt = S_OUT;
            end else if (stat.tix_blocked && stat.bsem_ok) begin
              cmd.op    = OP_QSETUP;
              state_nxt = S_QRD;
            end else begin
              state_nxt = S_TFIN;
            end
          end
          MD_SETPRI: begin
            cmd.op    = OP_SETPRI;
            state_nxt = S_OUT;
          end
          default: state_nxt = S_OUT;
        endcase
      end
      S_TICK: begin
        cmd.asel = A_SCAN;
        cmd.op   = OP_TICK_STEP;
        if (stat.scan_last) begin
          state_nxt = stat.preempt ? S_PINIT : S_OUT;
        end
      end
      S_CREATE: begin
        cmd.asel = A_SCAN;
        cmd.op   = OP_CREATE_STEP;
        if (stat.cand_invalid || stat.scan_last) begin
          state_nxt = S_OUT;
        end
      end
      S_QRD: begin
        cmd.op    = OP_QREAD;
        state_nxt = S_QCMP;
      end
      S_QCMP: begin
        cmd.op = OP_QCMP;
        if (stat.q_match) begin
          state_nxt = stat.q_more ? S_SRD : S_QDONE;
        end else begin
          state_nxt = stat.q_more ? S_QRD : S_TFIN;
        end
      end
      S_SRD: begin
        cmd.op    = OP_SREAD;
        state_nxt = S_SWR;
      end
      S_SWR: begin
        cmd.op    = OP_SWRITE;
        state_nxt = stat.q_more2 ? S_SRD : S_QDONE;
      end
      S_QDONE: begin
        cmd.op    = OP_QDONE;
        state_nxt = S_TFIN;
      end
      S_TFIN: begin
        cmd.asel  = stat.is_post ? A_QT : A_TIX;
        cmd.op    = OP_TFIN;
        state_nxt = stat.is_post ? S_PINIT : S_OUT;
      end
      S_PINIT: begin
        cmd.op    = OP_PINIT;
        state_nxt = S_PSCAN;
      end
      S_PSCAN: begin
        cmd.asel = A_SCAN;
        cmd.op   = OP_PSTEP;
        if (stat.scan_last) begin
          state_nxt = S_PFIN;
        end
      end
      S_PFIN: begin
        cmd.asel  = A_PICK;
        cmd.op    = OP_PFIN;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (stat.out_free) begin
          cmd.op    = OP_OUT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// ----- hdl/rtsk_dp.sv -----
// ----------------------------------------------------------------------------
// rtsk_dp
// Kernel datapath: task table, semaphore counts and queue lengths, queue
// entry RAM, scan registers, configuration and the result register.
// ----------------------------------------------------------------------------
module rtsk_dp #(
  parameter int TASKS           = 16,
  parameter int SEMAPHORES      = 5,
  parameter int QUEUE_DEPTH     = 8,
  parameter int PRIORITY_LEVELS = 8
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  rtsk_pkg::ctl_cmd_t        cmd,
  output rtsk_pkg::dp_stat_t        stat,
  input  logic [3:0]                in_mode,
  input  logic [rtsk_pkg::TIW-1:0]  in_task_index,
  input  logic [rtsk_pkg::PRW-1:0]  in_priority_value,
  input  logic [rtsk_pkg::TKW-1:0]  in_sleep_ticks,
  input  logic [rtsk_pkg::SMW-1:0]  in_sem_index,
  input  logic                      cfg_valid,
  input  logic [2:0]                cfg_index,
  input  logic [rtsk_pkg::CNW-1:0]  cfg_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [rtsk_pkg::TIW-1:0]  out_next_task,
  output logic                      out_switched,
  output logic                      out_first_run,
  output logic [rtsk_pkg::TIW-1:0]  out_created_slot,
  output logic [1:0]                out_status
);

  import rtsk_pkg::*;

  localparam int TW        = $clog2(TASKS);
  localparam int SW        = (SEMAPHORES > 1) ? $clog2(SEMAPHORES) : 1;
  localparam int QLW       = $clog2(QUEUE_DEPTH + 1);
  localparam int RAM_DEPTH = SEMAPHORES * QUEUE_DEPTH;
  localparam int RAM_AW    = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1;

  // task table
  logic [2:0]     st_r   [TASKS];
  logic [PRW-1:0] tpri_r [TASKS];
  logic [TKW-1:0] slp_r  [TASKS];
  logic [SMW-1:0] bsem_r [TASKS];

  // semaphores
  logic [CNW-1:0] cnt_r  [SEMAPHORES];
  logic [QLW-1:0] qlen_r [SEMAPHORES];

  logic           rr_mode_r, preempt_r;
  logic [TIW-1:0] cur_task_r, rr_ptr_r;

  // request registers
  logic [3:0]     mode_r;
  logic [TIW-1:0] tix_r;
  logic [PRW-1:0] pri_r;
  logic [TKW-1:0] ticks_r;
  logic [SMW-1:0] sem_r;
  logic [1:0]     status_r;
  logic [TIW-1:0] created_r;
  logic           switched_r, fresh_r;

  // scan and queue registers
  logic [TIW-1:0] sidx_r;
  logic [TW-1:0]  scnt_r;
  logic           found_r;
  logic [TIW-1:0] pick_r;
  logic [PRW-1:0] bestpri_r;
  logic [SMW-1:0] qsem_r;
  logic [TIW-1:0] qtarget_r;
  logic [QLW-1:0] pos_r;

  logic           out_valid_r;
  logic [TIW-1:0] out_next_task_r, out_created_slot_r;
  logic           out_switched_r, out_first_run_r;
  logic [1:0]     out_status_r;

  logic [TIW-1:0]    taddr;
  logic [TW-1:0]     ta;
  logic [2:0]        st_rd;
  logic [PRW-1:0]    pri_rd;
  logic [TKW-1:0]    slp_rd;
  logic [SMW-1:0]    bsem_rd;
  logic [SW-1:0]     si, qi, cfg_si;
  logic [SMW-1:0]    cfg_sidx;
  logic              sem_ok, tix_in, is_post, runnable, wait_enq;
  logic [TIW-1:0]    sidx_inc, start, start_inc;
  logic [PRW-1:0]    pri_sat;
  logic [RAM_AW-1:0] qbase_q, qbase_s;
  logic              ram_we, ram_re;
  logic [RAM_AW-1:0] ram_waddr, ram_raddr;
  logic [TIW-1:0]    ram_wdata, ram_rdata;

  always_comb begin
    unique case (cmd.asel)
      A_TIX:   taddr = tix_r;
      A_CUR:   taddr = cur_task_r;
      A_SCAN:  taddr = sidx_r;
      A_QT:    taddr = qtarget_r;
      A_PICK:  taddr = pick_r;
      default: taddr = tix_r;
    endcase
  end

  assign ta      = taddr[TW-1:0];
  assign st_rd   = st_r[ta];
  assign pri_rd  = tpri_r[ta];
  assign slp_rd  = slp_r[ta];
  assign bsem_rd = bsem_r[ta];

  assign si       = sem_r[SW-1:0];
  assign qi       = qsem_r[SW-1:0];
  assign sem_ok   = {1'b0, sem_r} < (SMW+1)'(SEMAPHORES);
  assign tix_in   = {1'b0, tix_r} < (TIW+1)'(TASKS);
  assign is_post  = (mode_r == MD_POST);
  assign runnable = (st_rd == ST_READY) || (st_rd == ST_UNRUN);
  assign wait_enq = sem_ok && (st_rd == ST_READY) && (cnt_r[si] == '0) &&
                    (qlen_r[si] < QLW'(QUEUE_DEPTH));

  assign sidx_inc  = (sidx_r == TIW'(TASKS - 1)) ? '0 : sidx_r + 1'b1;
  assign start     = rr_mode_r ? rr_ptr_r : cur_task_r;
  assign start_inc = (start == TIW'(TASKS - 1)) ? '0 : start + 1'b1;

  assign pri_sat = ({1'b0, in_priority_value} >= (PRW+1)'(PRIORITY_LEVELS)) ?
                   PRW'(PRIORITY_LEVELS - 1) : in_priority_value;

  assign cfg_sidx = cfg_index - CFG_SEM0;
  assign cfg_si   = cfg_sidx[SW-1:0];

  assign qbase_q = RAM_AW'(32'(qsem_r) * 32'(QUEUE_DEPTH));
  assign qbase_s = RAM_AW'(32'(sem_r) * 32'(QUEUE_DEPTH));

  // status to the sequencer
  always_comb begin
    stat.mode         = mode_r;
    stat.tix_ok       = tix_in && (st_rd != ST_INVALID);
    stat.tix_blocked  = (st_rd == ST_BLOCKED);
    stat.bsem_ok      = {1'b0, bsem_rd} < (SMW+1)'(SEMAPHORES);
    stat.sem_ok       = sem_ok;
    stat.qlen_nz      = (qlen_r[si] != '0);
    stat.scan_last    = (scnt_r == TW'(TASKS - 1));
    stat.cand_invalid = (st_rd == ST_INVALID);
    stat.q_match      = is_post || (ram_rdata == qtarget_r);
    stat.q_more       = ((QLW+1)'(pos_r) + 1'b1) < (QLW+1)'(qlen_r[qi]);
    stat.q_more2      = ((QLW+1)'(pos_r) + 2'd2) < (QLW+1)'(qlen_r[qi]);
    stat.is_post      = is_post;
    stat.preempt      = preempt_r;
    stat.out_free     = !out_valid_r || out_ready;
  end

  // queue RAM access
  always_comb begin
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = qbase_q + RAM_AW'(pos_r);
    ram_raddr = qbase_q + RAM_AW'(pos_r);
    ram_wdata = ram_rdata;
    unique case (cmd.op)
      OP_QREAD:  ram_re = 1'b1;
      OP_SREAD: begin
        ram_re    = 1'b1;
        ram_raddr = qbase_q + RAM_AW'(pos_r) + 1'b1;
      end
      OP_SWRITE: ram_we = 1'b1;
      OP_WAIT: begin
        ram_we    = wait_enq;
        ram_waddr = qbase_s + RAM_AW'(qlen_r[si]);
        ram_wdata = cur_task_r;
      end
      default: ram_we = 1'b0;
    endcase
  end

  rtsk_ram #(
    .WIDTH (TIW),
    .DEPTH (RAM_DEPTH)
  ) u_qram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TASKS; i++) begin
        st_r[i]   <= ST_INVALID;
        tpri_r[i] <= '0;
        slp_r[i]  <= '0;
        bsem_r[i] <= '0;
      end
      for (int s = 0; s < SEMAPHORES; s++) begin
        cnt_r[s]  <= '0;
        qlen_r[s] <= '0;
      end
      rr_mode_r   <= 1'b0;
      preempt_r   <= 1'b0;
      cur_task_r  <= '0;
      rr_ptr_r    <= TIW'(TASKS - 1);
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.op == OP_OUT) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end

      if (cfg_valid) begin
        if (cfg_index == CFG_RR) begin
          rr_mode_r <= cfg_data[0];
        end else if (cfg_index == CFG_PREEMPT) begin
          preempt_r <= cfg_data[0];
        end else if ({1'b0, cfg_sidx} < (SMW+1)'(SEMAPHORES)) begin
          cnt_r[cfg_si] <= cfg_data;
        end
      end

      unique case (cmd.op)
        OP_LOAD: begin
          mode_r     <= in_mode;
          tix_r      <= in_task_index;
          pri_r      <= pri_sat;
          ticks_r    <= in_sleep_ticks;
          sem_r      <= in_sem_index;
          status_r   <= STS_OK;
          created_r  <= '0;
          switched_r <= 1'b0;
          fresh_r    <= 1'b0;
          sidx_r     <= '0;
          scnt_r     <= '0;
        end
        OP_SLEEP: begin
          if (st_rd == ST_READY) begin
            slp_r[ta] <= ticks_r;
            st_r[ta]  <= (ticks_r == '0) ? ST_READY : ST_DELAYED;
          end
        end
        OP_WAIT: begin
          if (sem_ok && st_rd == ST_READY) begin
            if (cnt_r[si] != '0) begin
              cnt_r[si] <= cnt_r[si] - 1'b1;
            end else if (wait_enq) begin
              st_r[ta]   <= ST_BLOCKED;
              bsem_r[ta] <= sem_r;
              qlen_r[si] <= qlen_r[si] + 1'b1;
            end else begin
              status_r <= STS_QFULL;
            end
          end
        end
        OP_POST_CNT: begin
          if (sem_ok && cnt_r[si] != COUNT_MAX) begin
            cnt_r[si] <= cnt_r[si] + 1'b1;
          end
        end
        OP_QSETUP: begin
          pos_r     <= '0;
          qtarget_r <= tix_r;
          qsem_r    <= is_post ? sem_r : bsem_rd;
        end
        OP_QCMP: begin
          if (is_post) begin
            qtarget_r <= ram_rdata;
          end
          if (!stat.q_match) begin
            pos_r <= pos_r + 1'b1;
          end
        end
        OP_SWRITE: pos_r <= pos_r + 1'b1;
        OP_QDONE:  qlen_r[qi] <= qlen_r[qi] - 1'b1;
        OP_TFIN: begin
          if (is_post) begin
            st_r[ta] <= ST_READY;
          end else begin
            st_r[ta]  <= (mode_r == MD_DESTROY) ? ST_INVALID : ST_UNRUN;
            slp_r[ta] <= '0;
          end
        end
        OP_TICK_STEP: begin
          if (st_rd == ST_DELAYED) begin
            if (slp_rd == '0) begin
              st_r[ta] <= ST_READY;
            end else begin
              slp_r[ta] <= slp_rd - 1'b1;
            end
          end
          sidx_r <= sidx_inc;
          scnt_r <= scnt_r + 1'b1;
        end
        OP_CREATE_STEP: begin
          if (st_rd == ST_INVALID) begin
            st_r[ta]   <= ST_UNRUN;
            tpri_r[ta] <= pri_r;
            slp_r[ta]  <= '0;
            bsem_r[ta] <= '0;
            created_r  <= sidx_r;
          end else if (stat.scan_last) begin
            status_r <= STS_NOSLOT;
          end
          sidx_r <= sidx_inc;
          scnt_r <= scnt_r + 1'b1;
        end
        OP_SETPRI: begin
          if (tix_in) begin
            tpri_r[ta] <= pri_r;
          end
        end
        OP_PINIT: begin
          sidx_r  <= start_inc;
          scnt_r  <= '0;
          found_r <= 1'b0;
        end
        OP_PSTEP: begin
          // first runnable in scan order; priority mode keeps strictly better
          if (runnable && (!found_r || (!rr_mode_r && pri_rd < bestpri_r))) begin
            pick_r    <= sidx_r;
            bestpri_r <= pri_rd;
            found_r   <= 1'b1;
          end
          sidx_r <= sidx_inc;
          scnt_r <= scnt_r + 1'b1;
        end
        OP_PFIN: begin
          if (!found_r) begin
            if (status_r == STS_OK) begin
              status_r <= STS_NONE;
            end
          end else begin
            cur_task_r <= pick_r;
            switched_r <= 1'b1;
            if (st_rd == ST_UNRUN) begin
              st_r[ta] <= ST_READY;
              fresh_r  <= 1'b1;
            end
            if (rr_mode_r) begin
              rr_ptr_r <= pick_r;
            end
          end
        end
        OP_OUT: begin
          out_next_task_r    <= cur_task_r;
          out_switched_r     <= switched_r;
          out_first_run_r    <= fresh_r;
          out_created_slot_r <= created_r;
          out_status_r       <= status_r;
        end
        default: begin
        end
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_next_task    = out_next_task_r;
  assign out_switched     = out_switched_r;
  assign out_first_run    = out_first_run_r;
  assign out_created_slot = out_created_slot_r;
  assign out_status       = out_status_r;

endmodule

// ----- hdl/rtos_task_scheduler_kernel.sv -----
// ----------------------------------------------------------------------------
// rtos_task_scheduler_kernel
// Hardware scheduler kernel: task table, counting semaphores with FIFO wait
// queues, priority or round-robin rescheduling.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one kernel request word per handshake (tick, yield, sleep, wait,
//           post, create, destroy, restart, set priority).
//   out_* : one result word per request: running task, switch flag,
//           first-run flag, created slot and status.
//   cfg_* : register writes (0 policy, 1 preemption, 2.. semaphore counts);
//           always ready, issue only while no request is in flight.
// Timing: one request at a time. Accept and decode come first, then
//   tick           table sweep
//   create         free-slot search
//   post/destroy   queue entries searched, then entries shifted, then queue update
//   reschedule     table scan (one table entry per cycle)
//   result         loaded into the output register
//   The single-read task table and the queue RAM port set the length of each step.
// Reset (rst_n low, synchronous): all slots invalid, counts and queues empty,
//   running task 0, round-robin pointer at the last slot.
// Output stall: the result word sits in an output register; the next request
//   is taken meanwhile and only its own result waits on out_ready.
// ----------------------------------------------------------------------------
module rtos_task_scheduler_kernel #(
  parameter int TASKS           = 16,
  parameter int SEMAPHORES      = 5,
  parameter int QUEUE_DEPTH     = 8,
  parameter int PRIORITY_LEVELS = 8
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // request channel
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [3:0]                in_mode,
  input  logic [rtsk_pkg::TIW-1:0]  in_task_index,
  input  logic [rtsk_pkg::PRW-1:0]  in_priority_value,
  input  logic [rtsk_pkg::TKW-1:0]  in_sleep_ticks,
  input  logic [rtsk_pkg::SMW-1:0]  in_sem_index,
  // result channel
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [rtsk_pkg::TIW-1:0]  out_next_task,
  output logic                      out_switched,
  output logic                      out_first_run,
  output logic [rtsk_pkg::TIW-1:0]  out_created_slot,
  output logic [1:0]                out_status,
  // register writes
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [2:0]                cfg_index,
  input  logic [rtsk_pkg::CNW-1:0]  cfg_data
);

  import rtsk_pkg::*;

  ctl_cmd_t cmd;
  dp_stat_t stat;

  // register writes never stall
  assign cfg_ready = 1'b1;

  rtsk_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  rtsk_dp #(
    .TASKS           (TASKS),
    .SEMAPHORES      (SEMAPHORES),
    .QUEUE_DEPTH     (QUEUE_DEPTH),
    .PRIORITY_LEVELS (PRIORITY_LEVELS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .in_mode           (in_mode),
    .in_task_index     (in_task_index),
    .in_priority_value (in_priority_value),
    .in_sleep_ticks    (in_sleep_ticks),
    .in_sem_index      (in_sem_index),
    .cfg_valid         (cfg_valid),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_next_task     (out_next_task),
    .out_switched      (out_switched),
    .out_first_run     (out_first_run),
    .out_created_slot  (out_created_slot),
    .out_status        (out_status)
  );

endmodule

// ----- tb/rtsk_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rtsk_checker
// Watches the request, result and register channels of the scheduler kernel,
// keeps its own copy of the task table and semaphores, predicts each result
// word and compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module rtsk_checker
  import rtsk_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_ready,
  input  logic [3:0]       in_mode,
  input  logic [TIW-1:0]   in_task_index,
  input  logic [PRW-1:0]   in_priority_value,
  input  logic [TKW-1:0]   in_sleep_ticks,
  input  logic [SMW-1:0]   in_sem_index,
  input  logic             out_valid,
  input  logic             out_ready,
  input  logic [TIW-1:0]   out_next_task,
  input  logic             out_switched,
  input  logic             out_first_run,
  input  logic [TIW-1:0]   out_created_slot,
  input  logic [1:0]       out_status,
  input  logic             cfg_valid,
  input  logic             cfg_ready,
  input  logic [2:0]       cfg_index,
  input  logic [CNW-1:0]   cfg_data,
  output int               fails,
  output int               words_left,
  output int               words_checked
);

  localparam int NT = 16;
  localparam int NS = 5;
  localparam int QD = 8;
  localparam int NL = 8;

  typedef struct packed {
    logic [TIW-1:0] next_task;
    logic           switched;
    logic           first_run;
    logic [TIW-1:0] created_slot;
    logic [1:0]     status;
  } sched_word_t;

  logic [2:0]     tstate [NT];
  logic [PRW-1:0] tpri   [NT];
  logic [TKW-1:0] tsleep [NT];
  logic [SMW-1:0] tbsem  [NT];
  logic [TIW-1:0] running;
  logic [TIW-1:0] rr_ptr;
  logic [CNW-1:0] scount [NS];
  logic [TIW-1:0] waiters [NS][QD];
  int             nwait  [NS];
  logic           rr_on, preempt_on;

  sched_word_t expected_words[$];

  function automatic bit runnable(int t);
    return tstate[t] == ST_READY || tstate[t] == ST_UNRUN;
  endfunction

  // next task to run, -1 if nothing is ready or unrun
  function automatic int choose_task();
    logic [TIW-1:0] idx;
    if (rr_on) begin
      idx = rr_ptr;
      for (int n = 0; n < NT; n++) begin
        idx = idx + 1'b1;
        if (runnable(idx)) begin
          rr_ptr = idx;
          return int'(idx);
        end
      end
      return -1;
    end
    for (int lvl = 0; lvl < NL; lvl++) begin
      idx = running;
      for (int n = 0; n < NT; n++) begin
        idx = idx + 1'b1;
        if (tpri[idx] == lvl && runnable(idx)) return int'(idx);
      end
    end
    return -1;
  endfunction

  function automatic void drop_waiter(int s, int t);
    if (s >= NS) return;
    for (int i = 0; i < nwait[s]; i++) begin
      if (waiters[s][i] == t) begin
        for (int j = i; j + 1 < nwait[s]; j++) waiters[s][j] = waiters[s][j+1];
        nwait[s]--;
        return;
      end
    end
  endfunction

  function automatic sched_word_t kernel_step(logic [3:0] md, logic [TIW-1:0] tix,
                                              logic [PRW-1:0] pv, logic [TKW-1:0] tk,
                                              logic [SMW-1:0] sm);
    sched_word_t r;
    logic [TIW-1:0] c;
    int slot, hd;
    bit resched;
    r = '0;
    c = running;
    resched = 0;
    r.status = STS_OK;
    case (md)
      MD_TICK: begin
        for (int i = 0; i < NT; i++)
          if (tstate[i] == ST_DELAYED) begin
            if (tsleep[i] == 0) tstate[i] = ST_READY;
            else tsleep[i] = tsleep[i] - 1'b1;
          end
        resched = preempt_on;
      end
      MD_YIELD: resched = 1;
      MD_SLEEP: begin
        if (tstate[c] == ST_READY) begin
          tsleep[c] = tk;
          tstate[c] = (tk == 0) ? ST_READY : ST_DELAYED;
        end
        resched = 1;
      end
      MD_WAIT: begin
        if (sm < NS && tstate[c] == ST_READY) begin
          if (scount[sm] > 0) scount[sm] = scount[sm] - 1'b1;
          else if (nwait[sm] < QD) begin
            tstate[c] = ST_BLOCKED;
            tbsem[c] = sm;
            waiters[sm][nwait[sm]] = c;
            nwait[sm]++;
          end else r.status = STS_QFULL;
        end
        resched = 1;
      end
      MD_POST: begin
        if (sm < NS) begin
          if (nwait[sm] > 0) begin
            hd = waiters[sm][0];
            drop_waiter(sm, hd);
            tstate[hd] = ST_READY;
          end else if (scount[sm] != COUNT_MAX) scount[sm] = scount[sm] + 1'b1;
        end
        resched = 1;
      end
      MD_CREATE: begin
        slot = -1;
        for (int i = 0; i < NT; i++)
          if (slot < 0 && tstate[i] == ST_INVALID) slot = i;
        if (slot < 0) r.status = STS_NOSLOT;
        else begin
          tstate[slot] = ST_UNRUN;
          tpri[slot] = pv;
          tsleep[slot] = '0;
          tbsem[slot] = '0;
          r.created_slot = slot[TIW-1:0];
        end
      end
      MD_DESTROY, MD_RESTART: begin
        if (tstate[tix] != ST_INVALID) begin
          if (tstate[tix] == ST_BLOCKED) drop_waiter(tbsem[tix], tix);
          tstate[tix] = (md == MD_DESTROY) ? ST_INVALID : ST_UNRUN;
          tsleep[tix] = '0;
        end
      end
      MD_SETPRI: tpri[tix] = pv;
      default: ;
    endcase
    if (resched) begin
      slot = choose_task();
      if (slot < 0) begin
        if (r.status == STS_OK) r.status = STS_NONE;
      end else begin
        running = slot[TIW-1:0];
        r.switched = 1'b1;
        if (tstate[slot] == ST_UNRUN) begin
          tstate[slot] = ST_READY;
          r.first_run = 1'b1;
        end
      end
    end
    r.next_task = running;
    return r;
  endfunction

  always @(posedge clk) begin
    sched_word_t got, want;
    if (!rst_n) begin
      for (int i = 0; i < NT; i++) begin
        tstate[i] = ST_INVALID;
        tpri[i] = '0;
        tsleep[i] = '0;
        tbsem[i] = '0;
      end
      for (int s = 0; s < NS; s++) begin
        scount[s] = '0;
        nwait[s] = 0;
      end
      running = '0;
      rr_ptr = TIW'(NT - 1);
      rr_on = 0;
      preempt_on = 0;
      expected_words.delete();
      fails = 0;
      words_checked = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_RR) rr_on = cfg_data[0];
        else if (cfg_index == CFG_PREEMPT) preempt_on = cfg_data[0];
        else if (cfg_index >= CFG_SEM0 && cfg_index < CFG_SEM0 + NS)
          scount[cfg_index - CFG_SEM0] = cfg_data;
      end
      if (in_valid && in_ready)
        expected_words.push_back(kernel_step(in_mode, in_task_index, in_priority_value,
                                             in_sleep_ticks, in_sem_index));
      if (out_valid && out_ready) begin
        got = '{out_next_task, out_switched, out_first_run, out_created_slot, out_status};
        if (expected_words.size() == 0) begin
          if (fails < 10) $display("unexpected result word %p", got);
          fails++;
        end else begin
          want = expected_words.pop_front();
          words_checked++;
          if (got != want) begin
            if (fails < 10)
              $display("mismatch at word %0d: expected %p, got %p", words_checked, want, got);
            fails++;
          end
        end
      end
    end
    words_left = expected_words.size();
  end

endmodule

// ----- tb/tb_rtos_task_scheduler_kernel.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rtos_task_scheduler_kernel
// Drives kernel requests and register writes into the scheduler, throttles
// the result side, and reports the verdict from the checker's mismatch count.
// ----------------------------------------------------------------------------
module tb_rtos_task_scheduler_kernel;
  import rtsk_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int PHASES      = 5;
  localparam int PER_PHASE   = 270;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_ready;
  logic [3:0]     in_mode = '0;
  logic [TIW-1:0] in_task_index = '0;
  logic [PRW-1:0] in_priority_value = '0;
  logic [TKW-1:0] in_sleep_ticks = '0;
  logic [SMW-1:0] in_sem_index = '0;
  logic out_valid;
  logic out_ready = 0;
  logic [TIW-1:0] out_next_task;
  logic out_switched, out_first_run;
  logic [TIW-1:0] out_created_slot;
  logic [1:0]     out_status;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [2:0]     cfg_index = '0;
  logic [CNW-1:0] cfg_data = '0;

  int  fails, words_left, words_checked;
  int  cycles = 0;
  int  requests_sent = 0;
  int  cfg_writes = 0;
  bit  gaps_on = 1;       // random idle bursts on both sides
  bit  hold_results = 0;  // asks the result side for one long stall

  rtos_task_scheduler_kernel u_top (.*);

  rtsk_checker u_chk (.*);

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  // result side: random stalls, plus one long hold-off so the block backs up
  initial begin
    @(posedge clk iff rst_n);
    forever begin
      if (hold_results) begin
        out_ready <= 0;
        repeat (400) @(posedge clk);
        hold_results = 0;
      end else if (gaps_on && $urandom_range(0, 3) == 0) begin
        out_ready <= 0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end else begin
        out_ready <= 1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  // one request word; valid stays up until the block takes it
  task automatic send_req(logic [3:0] md, logic [TIW-1:0] tix, logic [PRW-1:0] pv,
                          logic [TKW-1:0] tk, logic [SMW-1:0] sm);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid <= 1;
    in_mode <= md;
    in_task_index <= tix;
    in_priority_value <= pv;
    in_sleep_ticks <= tk;
    in_sem_index <= sm;
    do @(posedge clk); while (!in_ready);
    requests_sent++;
  endtask

  // let every outstanding word come back before touching registers
  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (words_left != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // one register write, then the port goes idle
  task automatic write_reg(logic [2:0] idx, logic [CNW-1:0] d);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    @(posedge clk);
    cfg_writes++;
  endtask

  // mostly meaningful kernel calls; semaphores 0 and 1 get crowded so wait
  // queues fill, a few out-of-range semaphores and unknown modes as noise
  task automatic send_random();
    int w;
    logic [3:0] md;
    logic [TKW-1:0] tk;
    logic [SMW-1:0] sm;
    w = $urandom_range(0, 99);
    if (w < 14)      md = MD_TICK;
    else if (w < 24) md = MD_YIELD;
    else if (w < 32) md = MD_SLEEP;
    else if (w < 52) md = MD_WAIT;
    else if (w < 64) md = MD_POST;
    else if (w < 80) md = MD_CREATE;
    else if (w < 87) md = MD_DESTROY;
    else if (w < 92) md = MD_RESTART;
    else if (w < 98) md = MD_SETPRI;
    else             md = 4'($urandom_range(9, 15));
    w = $urandom_range(0, 9);
    tk = (w < 7) ? TKW'($urandom_range(0, 6)) : (w < 8) ? '0 : TKW'($urandom);
    w = $urandom_range(0, 19);
    sm = (w < 10) ? SMW'($urandom_range(0, 1)) :
         (w < 17) ? SMW'($urandom_range(0, 4)) : SMW'($urandom_range(0, 7));
    send_req(md, TIW'($urandom), PRW'($urandom), tk, sm);
  endtask

  initial begin
    logic [CNW-1:0] cnt;
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: empty table, creation, first runs, sleeps, semaphore edges
    write_reg(CFG_SEM0 + 3'd4, COUNT_MAX);
    send_req(MD_YIELD, 0, 0, 0, 0);          // nothing to run
    send_req(MD_CREATE, 0, 7, 0, 0);
    send_req(MD_CREATE, 0, 0, 0, 0);
    send_req(MD_YIELD, 0, 0, 0, 0);          // fresh start of the level-0 task
    send_req(MD_TICK, 0, 0, 0, 0);
    send_req(MD_SLEEP, 0, 0, 0, 0);          // zero ticks: stays ready
    send_req(MD_SLEEP, 0, 0, 3, 0);
    send_req(MD_TICK, 0, 0, 0, 0);
    send_req(MD_YIELD, 0, 0, 0, 0);
    send_req(MD_WAIT, 0, 0, 0, 0);           // count zero: blocks
    send_req(MD_POST, 0, 0, 0, 0);           // wakes the waiter
    send_req(MD_POST, 0, 0, 0, 4);           // count already saturated
    send_req(MD_WAIT, 0, 0, 0, 5);           // semaphore out of range
    send_req(MD_POST, 0, 0, 0, 7);
    send_req(MD_SETPRI, 15, 7, 0, 0);        // slot never created
    send_req(MD_SETPRI, 1, 7, 0, 0);
    send_req(MD_RESTART, 1, 0, 0, 0);
    send_req(MD_DESTROY, 0, 0, 0, 0);        // running task destroyed
    send_req(MD_DESTROY, 0, 0, 0, 0);        // already invalid
    send_req(MD_RESTART, 0, 0, 0, 0);
    send_req(4'd9, 0, 0, 0, 0);
    send_req(4'd15, 15, 7, 16'hFFFF, 7);
    send_req(MD_SLEEP, 0, 0, 16'hFFFF, 0);
    send_req(MD_TICK, 0, 0, 0, 0);
    drain();

    // random phases, each under its own policy and semaphore counts
    for (int p = 0; p < PHASES; p++) begin
      write_reg(CFG_RR, (p == 1 || p == 3) ? 8'hFF : 8'h00);
      write_reg(CFG_PREEMPT, (p >= 2) ? 8'h01 : 8'h00);
      for (int s = 0; s < 5; s++) begin
        cnt = (p == 0) ? 8'h00 : (p == 1) ? 8'hFF : 8'($urandom_range(0, 3));
        write_reg(CFG_SEM0 + 3'(s), cnt);
      end
      if (p == 2) write_reg(3'd7, 8'hA5);     // index past the register list
      if (p == PHASES - 1) gaps_on = 0;
      for (int i = 0; i < PER_PHASE; i++) begin
        if (p == 1 && i == 100) hold_results = 1;
        send_random();
      end
      drain();
    end

    while (words_left != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    $display("%0d requests over %0d register settings, %0d result words checked",
             requests_sent, cfg_writes, words_checked);
    $display("priority and round-robin policies, with and without preemptive ticks");
    if (fails == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", fails);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- rtos_task_scheduler_kernel.f -----
hdl/rtsk_pkg.sv
hdl/rtsk_ram.sv
hdl/rtsk_ctrl.sv
hdl/rtsk_dp.sv
hdl/rtos_task_scheduler_kernel.sv
tb/rtsk_checker.sv
tb/tb_rtos_task_scheduler_kernel.sv
